// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the block energy rise detector.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/bedr_pkg.sv =====
// ----------------------------------------------------------------------------
// bedr_pkg
// Types and constants shared by the block energy rise detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bedr_pkg;

   localparam int ENERGY_W    = 42;
   localparam int OFFSET_W    = 32;
   localparam int ALPHA_W     = 16;
   localparam int BLK_LEN_W   = 11;
   localparam int CSR_INDEX_W = 2;
   localparam int HALF_W      = ENERGY_W / 2;
   localparam int PP_W        = ALPHA_W + HALF_W;
   localparam int PROD_W      = ALPHA_W + ENERGY_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA          = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_LEN      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_ENERGY = 2'd2;

   localparam logic [ENERGY_W-1:0]  ENERGY_MAX      = '1;
   localparam logic [OFFSET_W-1:0]  OFFSET_MAX      = '1;
   localparam logic [ENERGY_W-1:0]  ENERGY_RESET    = 42'd47110815;
   localparam logic [ALPHA_W-1:0]   ALPHA_RESET     = 16'd256;
   localparam logic [BLK_LEN_W-1:0] BLOCK_LEN_RESET = 11'd64;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef struct packed {
      logic                   en;
      logic [CSR_INDEX_W-1:0] index;
      logic [ENERGY_W-1:0]    data;
   } cfg_write_type;

   typedef struct packed {
      logic [ENERGY_W-1:0] energy;
      logic [OFFSET_W-1:0] offset;
   } blk_word_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== design/bedr_front.sv =====
// ----------------------------------------------------------------------------
// bedr_front
// Accepts samples, squares them, sums block energy and counts offsets; pushes
// one word per finished block into the queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bedr_front #(
   parameter int MAX_BLOCK_LEN = 1024,
   parameter int SAMPLE_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bedr_pkg::cfg_write_type       cfg,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_i,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_q,
   input  logic                          req_new_search,
   output logic                          q_push,
   output bedr_pkg::blk_word_type        q_word,
   input  bedr_pkg::queue_status_type    q_status
);

   localparam int SQ_W  = 2 * SAMPLE_BITS - 1;
   localparam int ADD_W = 2 * SAMPLE_BITS;
   localparam int SUM_W = ((ADD_W > bedr_pkg::ENERGY_W) ? ADD_W : bedr_pkg::ENERGY_W) + 1;
   localparam int CNT_W = $clog2(MAX_BLOCK_LEN + 1);
   localparam int LEN_W = (CNT_W > bedr_pkg::BLK_LEN_W) ? CNT_W : bedr_pkg::BLK_LEN_W;

   logic [bedr_pkg::BLK_LEN_W-1:0] block_len_ff;
   logic                           f1_valid_ff, f1_valid_in;
   logic [SQ_W-1:0]                f1_sq_i_ff, f1_sq_q_ff;
   logic                           f1_new_ff;
   logic [bedr_pkg::ENERGY_W-1:0]  energy_sum_ff, energy_sum_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [bedr_pkg::OFFSET_W-1:0]  offset_ff, offset_in;

   logic signed [2*SAMPLE_BITS-1:0] prod_i, prod_q;
   logic [bedr_pkg::ENERGY_W-1:0]   base_sum, sat_sum;
   logic [CNT_W-1:0]                base_cnt, cnt_next;
   logic [bedr_pkg::OFFSET_W-1:0]   base_off, off_next;
   logic [ADD_W-1:0]                add;
   logic [SUM_W-1:0]                sum_wide;
   logic [bedr_pkg::OFFSET_W:0]     off_wide;
   logic [LEN_W-1:0]                len_raw, eff_len;
   logic                            block_end, f1_go, accept;

   assign prod_i = ADD_W'(req_sample_i) * ADD_W'(req_sample_i);
   assign prod_q = ADD_W'(req_sample_q) * ADD_W'(req_sample_q);

   always_comb begin
      base_sum = f1_new_ff ? '0 : energy_sum_ff;
      base_cnt = f1_new_ff ? '0 : cnt_ff;
      base_off = f1_new_ff ? '0 : offset_ff;
      add      = {1'b0, f1_sq_i_ff} + {1'b0, f1_sq_q_ff};
      sum_wide = SUM_W'(base_sum) + SUM_W'(add);
      sat_sum  = (sum_wide > SUM_W'(bedr_pkg::ENERGY_MAX)) ? bedr_pkg::ENERGY_MAX
                                                           : sum_wide[bedr_pkg::ENERGY_W-1:0];
      cnt_next = base_cnt + CNT_W'(1);
      off_wide = {1'b0, base_off} + (bedr_pkg::OFFSET_W + 1)'(cnt_next);
      off_next = off_wide[bedr_pkg::OFFSET_W] ? bedr_pkg::OFFSET_MAX
                                              : off_wide[bedr_pkg::OFFSET_W-1:0];
      len_raw  = LEN_W'(block_len_ff);
      if (len_raw == '0) begin
         eff_len = LEN_W'(1);
      end else if (len_raw > LEN_W'(MAX_BLOCK_LEN)) begin
         eff_len = LEN_W'(MAX_BLOCK_LEN);
      end else begin
         eff_len = len_raw;
      end
      block_end = LEN_W'(cnt_next) >= eff_len;
      f1_go     = !block_end || !q_status.full;
      req_stall = f1_valid_ff && !f1_go;
      accept    = req_valid && !req_stall;
      q_push    = f1_valid_ff && block_end && !q_status.full;
      q_word.energy = sat_sum;
      q_word.offset = base_off;

      f1_valid_in   = req_stall ? f1_valid_ff : req_valid;
      energy_sum_in = energy_sum_ff;
      cnt_in        = cnt_ff;
      offset_in     = offset_ff;
      if (f1_valid_ff && f1_go) begin
         if (block_end) begin
            energy_sum_in = '0;
            cnt_in        = '0;
            offset_in     = off_next;
         end else begin
            energy_sum_in = sat_sum;
            cnt_in        = cnt_next;
            offset_in     = base_off;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_len_ff  <= bedr_pkg::BLOCK_LEN_RESET;
         f1_valid_ff   <= 1'b0;
         energy_sum_ff <= '0;
         cnt_ff        <= '0;
         offset_ff     <= '0;
      end else begin
         if (cfg.en && cfg.index == bedr_pkg::CSR_BLOCK_LEN) begin
            block_len_ff <= cfg.data[bedr_pkg::BLK_LEN_W-1:0];
         end
         f1_valid_ff   <= f1_valid_in;
         energy_sum_ff <= energy_sum_in;
         cnt_ff        <= cnt_in;
         offset_ff     <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_sq_i_ff <= prod_i[SQ_W-1:0];
         f1_sq_q_ff <= prod_q[SQ_W-1:0];
         f1_new_ff  <= req_new_search;
      end
   end

   `ASSERT_IMPLY(fr_stall_only_full, clock, reset, req_stall, q_status.full && f1_valid_ff)
   `ASSERT_NEXT(fr_end_clears_count, clock, reset, q_push, cnt_ff == '0)

endmodule

`default_nettype wire

// ===== design/bedr_queue.sv =====
// ----------------------------------------------------------------------------
// bedr_queue
// Short first-in first-out queue of finished block words between the front
// and the back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bedr_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  bedr_pkg::blk_word_type     push_word,
   input  logic                       pop,
   output bedr_pkg::blk_word_type     pop_word,
   output bedr_pkg::queue_status_type status
);

   bedr_pkg::blk_word_type              entry_ff [bedr_pkg::QUEUE_DEPTH];
   logic [bedr_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [bedr_pkg::QUEUE_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                                do_push, do_pop;

   always_comb begin
      status.full  = cnt_ff == bedr_pkg::QUEUE_CNT_W'(bedr_pkg::QUEUE_DEPTH);
      status.empty = cnt_ff == '0;
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      pop_word     = entry_ff[rd_ptr_ff];
      cnt_in       = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + bedr_pkg::QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - bedr_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + bedr_pkg::QUEUE_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + bedr_pkg::QUEUE_PTR_W'(1);
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   `ASSERT_ALWAYS(qu_cnt_bound, clock, reset,
                  cnt_ff <= bedr_pkg::QUEUE_CNT_W'(bedr_pkg::QUEUE_DEPTH))
   `ASSERT_ALWAYS(qu_no_push_full, clock, reset, !(push && status.full))

endmodule

`default_nettype wire

// ===== design/bedr_back.sv =====
// ----------------------------------------------------------------------------
// bedr_back
// Pops block words, forms alpha times previous energy in two partial products,
// compares against the new energy and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bedr_back (
   input  logic                           clock,
   input  logic                           reset,
   input  bedr_pkg::cfg_write_type        cfg,
   input  bedr_pkg::blk_word_type         q_word,
   input  bedr_pkg::queue_status_type     q_status,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_detected,
   output logic [bedr_pkg::OFFSET_W-1:0]  rsp_block_offset,
   output logic [bedr_pkg::ENERGY_W-1:0]  rsp_block_energy
);

   localparam int HI_W = bedr_pkg::ENERGY_W - bedr_pkg::HALF_W;

   logic [bedr_pkg::ALPHA_W-1:0]  alpha_ff;
   logic [bedr_pkg::ENERGY_W-1:0] prev_ff;
   logic                          s1_valid_ff, s1_valid_in;
   logic [bedr_pkg::PP_W-1:0]     s1_pp_lo_ff;
   logic [bedr_pkg::ALPHA_W+HI_W-1:0] s1_pp_hi_ff;
   logic [bedr_pkg::ENERGY_W-1:0] s1_energy_ff;
   logic [bedr_pkg::OFFSET_W-1:0] s1_offset_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_detected_ff;
   logic [bedr_pkg::OFFSET_W-1:0] rsp_offset_ff;
   logic [bedr_pkg::ENERGY_W-1:0] rsp_energy_ff;

   logic                          out_adv, s1_free, hit;
   logic [bedr_pkg::PROD_W-1:0]   product, target;

   always_comb begin
      out_adv     = !rsp_valid_ff || !rsp_stall;
      s1_free     = !s1_valid_ff || out_adv;
      q_pop       = !q_status.empty && s1_free;
      s1_valid_in = q_pop ? 1'b1 : (out_adv ? 1'b0 : s1_valid_ff);
      product     = {s1_pp_hi_ff, {bedr_pkg::HALF_W{1'b0}}}
                    + bedr_pkg::PROD_W'(s1_pp_lo_ff);
      target      = bedr_pkg::PROD_W'({s1_energy_ff, 8'b0});
      hit         = product < target;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= bedr_pkg::ALPHA_RESET;
         prev_ff      <= bedr_pkg::ENERGY_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg.en && cfg.index == bedr_pkg::CSR_ALPHA) begin
            alpha_ff <= cfg.data[bedr_pkg::ALPHA_W-1:0];
         end
         if (cfg.en && cfg.index == bedr_pkg::CSR_INITIAL_ENERGY) begin
            prev_ff <= cfg.data;
         end else if (q_pop) begin
            prev_ff <= q_word.energy;
         end
         s1_valid_ff <= s1_valid_in;
         if (out_adv) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_pp_lo_ff  <= bedr_pkg::PP_W'(alpha_ff)
                         * bedr_pkg::PP_W'(prev_ff[bedr_pkg::HALF_W-1:0]);
         s1_pp_hi_ff  <= (bedr_pkg::ALPHA_W + HI_W)'(alpha_ff)
                         * (bedr_pkg::ALPHA_W + HI_W)'(
                              prev_ff[bedr_pkg::ENERGY_W-1:bedr_pkg::HALF_W]);
         s1_energy_ff <= q_word.energy;
         s1_offset_ff <= q_word.offset;
      end
      if (out_adv && s1_valid_ff) begin
         rsp_detected_ff <= hit;
         rsp_offset_ff   <= s1_offset_ff;
         rsp_energy_ff   <= s1_energy_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_detected     = rsp_detected_ff;
   assign rsp_block_offset = rsp_offset_ff;
   assign rsp_block_energy = rsp_energy_ff;

   `ASSERT_NEXT(bk_s1_to_out, clock, reset, s1_valid_ff && out_adv, rsp_valid_ff)
   `ASSERT_NEXT(bk_prev_tracks, clock, reset, q_pop && !cfg.en,
                prev_ff == $past(q_word.energy))

endmodule

`default_nettype wire

// ===== design/block_energy_rise_detector_unit.sv =====
// A result word passes the front sample, queue, back product and result registers.
// One sample per cycle when not stalled; with block length 1, one result per cycle
// when not stalled. The rate is set by the front accumulator's add and the 4-word
// queue. Reset is synchronous: counts, offset and partial sum clear, alpha loads
// 256, block length 64 and previous energy 47110815. No clearing pass is needed.
// ----------------------------------------------------------------------------
// block_energy_rise_detector_unit
// Block energy rise detector: front accumulator, word queue and compare back.
// ----------------------------------------------------------------------------
`default_nettype none

module block_energy_rise_detector_unit #(
   parameter int MAX_BLOCK_LEN = 1024,
   parameter int SAMPLE_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [bedr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bedr_pkg::ENERGY_W-1:0]       csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_i,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_q,
   input  logic                                req_new_search,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_detected,
   output logic [bedr_pkg::OFFSET_W-1:0]       rsp_block_offset,
   output logic [bedr_pkg::ENERGY_W-1:0]       rsp_block_energy
);

   bedr_pkg::cfg_write_type    cfg;
   bedr_pkg::blk_word_type     push_word, pop_word;
   bedr_pkg::queue_status_type q_status;
   logic                       q_push, q_pop;

   assign cfg.en    = csr_write_enable;
   assign cfg.index = csr_index;
   assign cfg.data  = csr_write_data;

   bedr_front #(
      .MAX_BLOCK_LEN (MAX_BLOCK_LEN),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_i   (req_sample_i),
      .req_sample_q   (req_sample_q),
      .req_new_search (req_new_search),
      .q_push         (q_push),
      .q_word         (push_word),
      .q_status       (q_status)
   );

   bedr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (push_word),
      .pop       (q_pop),
      .pop_word  (pop_word),
      .status    (q_status)
   );

   bedr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .q_word           (pop_word),
      .q_status         (q_status),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_detected     (rsp_detected),
      .rsp_block_offset (rsp_block_offset),
      .rsp_block_energy (rsp_block_energy)
   );

endmodule

`default_nettype wire

// ===== verif/tb_block_energy_rise_detector_unit.sv =====
// ----------------------------------------------------------------------------
// tb_block_energy_rise_detector_unit
// Self-checking bench for the block energy rise detector. A directed table
// covers register extremes, an ignored register index, a zero block length, a
// length cut mid-block and new searches; random phases then push about 500
// sample words under varied settings, an oversized length and idle patterns.
// Result fields are checked against typed rows or an in-bench energy model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_block_energy_rise_detector_unit;

   localparam int BLOCK_LEN_MAX   = 1024;
   localparam int SAMPLE_W        = 16;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 16;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int NUM_PHASES      = 12;
   localparam int PHASE_WORDS     = 28;
   localparam int BIG_PHASE_WORDS = 200;
   localparam logic [bedr_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_type;
   typedef enum logic [0:0] {ROW_CSR, ROW_WORD} row_kind_type;

   typedef struct packed {
      logic                          det;
      logic [bedr_pkg::OFFSET_W-1:0] off;
      logic [bedr_pkg::ENERGY_W-1:0] energy;
   } blk_result_type;

   typedef struct packed {
      row_kind_type                     kind;
      logic [bedr_pkg::CSR_INDEX_W-1:0] reg_idx;
      logic [bedr_pkg::ENERGY_W-1:0]    data;
      logic signed [15:0]               si;
      logic signed [15:0]               sq;
      logic                             ns;
      logic                             typed;
      blk_result_type                   want;
   } stim_row_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_write_enable = 1'b0;
   logic [bedr_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [bedr_pkg::ENERGY_W-1:0]    csr_write_data = '0;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic signed [SAMPLE_W-1:0]       req_sample_i = '0;
   logic signed [SAMPLE_W-1:0]       req_sample_q = '0;
   logic                             req_new_search = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic                             rsp_detected;
   logic [bedr_pkg::OFFSET_W-1:0]    rsp_block_offset;
   logic [bedr_pkg::ENERGY_W-1:0]    rsp_block_energy;

   idle_type       idle_mode = IDLE_NONE;
   blk_result_type pending_blocks[$];
   int unsigned    errors = 0;
   int unsigned    n_words = 0;
   int unsigned    n_results = 0;
   int unsigned    n_hits = 0;
   int unsigned    cycle_count = 0;

   // energy model state
   logic [bedr_pkg::ALPHA_W-1:0]   m_alpha;
   logic [bedr_pkg::BLK_LEN_W-1:0] m_len;
   logic [63:0]                    m_sum;
   logic [63:0]                    m_count;
   logic [63:0]                    m_off;
   logic [63:0]                    m_prev;

   stim_row_type dir_rows [25];

   block_energy_rise_detector_unit #(
      .MAX_BLOCK_LEN(BLOCK_LEN_MAX),
      .SAMPLE_BITS  (SAMPLE_W)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample_i    (req_sample_i),
      .req_sample_q    (req_sample_q),
      .req_new_search  (req_new_search),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_detected    (rsp_detected),
      .rsp_block_offset(rsp_block_offset),
      .rsp_block_energy(rsp_block_energy)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // advance the block model by one sample; return 1 when a block ends
   function automatic bit fold_sample(input logic signed [15:0] si,
                                      input logic signed [15:0] sq,
                                      input logic ns,
                                      output blk_result_type r);
      longint      a;
      longint      b;
      logic [63:0] add;
      logic [63:0] eff;
      logic [63:0] scaled_prev;
      a = si;
      b = sq;
      r = '0;
      if (ns) begin
         m_sum   = '0;
         m_count = '0;
         m_off   = '0;
      end
      add = 64'(a * a) + 64'(b * b);
      if (add > 64'(bedr_pkg::ENERGY_MAX) - m_sum) m_sum = 64'(bedr_pkg::ENERGY_MAX);
      else m_sum = m_sum + add;
      m_count = m_count + 1;
      eff = 64'(m_len);
      if (eff == 0) eff = 1;
      if (eff > BLOCK_LEN_MAX) eff = BLOCK_LEN_MAX;
      if (m_count < eff) return 1'b0;
      scaled_prev = 64'(m_alpha) * m_prev;
      r.det    = scaled_prev < (m_sum << 8);
      r.off    = m_off[bedr_pkg::OFFSET_W-1:0];
      r.energy = m_sum[bedr_pkg::ENERGY_W-1:0];
      m_prev = m_sum;
      if (m_count > 64'(bedr_pkg::OFFSET_MAX) - m_off) m_off = 64'(bedr_pkg::OFFSET_MAX);
      else m_off = m_off + m_count;
      m_sum   = '0;
      m_count = '0;
      return 1'b1;
   endfunction

   task automatic send_word(input logic signed [15:0] si, input logic signed [15:0] sq,
                            input logic ns, input logic typed, input blk_result_type want);
      blk_result_type r;
      int             pct;
      pct = (idle_mode == IDLE_SEND) ? 87 : (idle_mode == IDLE_BOTH) ? 8 : 0;
      while ($urandom_range(0, 99) < pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_sample_i   <= si;
      req_sample_q   <= sq;
      req_new_search <= ns;
      do @(posedge clock); while (req_stall);
      n_words++;
      if (fold_sample(si, sq, ns, r)) pending_blocks.push_back(typed ? want : r);
   endtask

   // drain, let the pipeline settle, then write one register
   task automatic write_reg(input logic [bedr_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [bedr_pkg::ENERGY_W-1:0] val);
      req_valid <= 1'b0;
      while (pending_blocks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         bedr_pkg::CSR_ALPHA:          m_alpha = val[bedr_pkg::ALPHA_W-1:0];
         bedr_pkg::CSR_BLOCK_LEN:      m_len = val[bedr_pkg::BLK_LEN_W-1:0];
         bedr_pkg::CSR_INITIAL_ENERGY: m_prev = 64'(val);
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (idle_mode == IDLE_RECV) rsp_stall <= $urandom_range(0, 99) < 87;
      else if (idle_mode == IDLE_BOTH) rsp_stall <= $urandom_range(0, 99) < 8;
      else rsp_stall <= 1'b0;
   end

   always @(posedge clock) begin : check_results
      blk_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (rsp_detected === 1'b1) n_hits++;
         if (pending_blocks.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word, expected none, actual det %0d off %0d energy %0d",
                     $realtime, rsp_detected, rsp_block_offset, rsp_block_energy);
         end else begin
            want = pending_blocks.pop_front();
            if (rsp_detected !== want.det) begin
               errors++;
               $display("%0t: detected mismatch, expected %0d, actual %0d",
                        $realtime, want.det, rsp_detected);
            end
            if (rsp_block_offset !== want.off) begin
               errors++;
               $display("%0t: block_offset mismatch, expected %0d, actual %0d",
                        $realtime, want.off, rsp_block_offset);
            end
            if (rsp_block_energy !== want.energy) begin
               errors++;
               $display("%0t: block_energy mismatch, expected %0d, actual %0d",
                        $realtime, want.energy, rsp_block_energy);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d result words outstanding",
                  $realtime, cycle_count, pending_blocks.size());
         $display("tb_block_energy_rise_detector_unit: FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      logic signed [15:0]             si;
      logic signed [15:0]             sq;
      logic                           ns;
      logic [bedr_pkg::ALPHA_W-1:0]   alpha_val;
      logic [bedr_pkg::BLK_LEN_W-1:0] len_val;
      logic [bedr_pkg::ENERGY_W-1:0]  init_val;
      int                             n_items;
      bit                             big;

      dir_rows = '{
         '{ROW_CSR,  bedr_pkg::CSR_BLOCK_LEN, 42'd0, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
         '{ROW_WORD, bedr_pkg::CSR_ALPHA, 42'd0, 16'sh8000, 16'sh8000, 1'b0, 1'b1,
           '{1'b1, 32'd0, 42'd2147483648}},
         '{ROW_WORD, bedr_pkg::CSR_ALPHA, 42'd0, 16'sd0, 16'sd0, 1'b0, 1'b1,
           '{1'b0, 32'd1, 42'd0}},
         '{ROW_WORD, bedr_pkg::CSR_ALPHA, 42'd0, 16'sd1, -16'sd1, 1'b0, 1'b1,
           '{1'b1, 32'd2, 42'd2}},
         '{ROW_WORD, bedr_pkg::CSR_ALPHA, 42'd0, 16'sh7fff, 16'sh7fff, 1'b1, 1'b1,
           '{1'b1, 32'd0, 42'd2147352578}},
         '{ROW_CSR,  bedr_pkg::CSR_ALPHA, 42'd0, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
         '{ROW_WORD, bedr_pkg::CSR_ALPHA, 42'd0, 16'sd0, 16'sd0, 1'b0, 1'b1,
           '{1'b0, 32'd1, 42'd0}},
         '{ROW_CSR,  bedr_pkg::CSR_ALPHA, 42'd65535, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
         '{ROW_CSR,  bedr_pkg::CSR_INITIAL_ENERGY, bedr_pkg::ENERGY_MAX,
           16'sd0, 16'sd0, 1'b0, 1'b0, '0},
         '{ROW_WORD, bedr_pkg::CSR_ALPHA, 42'd0, 16'sh8000, 16'sh8000, 1'b0, 1'b1,
           '{1'b0, 32'd2, 42'd2147483648}},
         '{ROW_CSR,  CSR_UNUSED, bedr_pkg::ENERGY_MAX, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
         '{ROW_WORD, bedr_pkg::CSR_ALPHA, 42'd0, 16'sd100, -16'sd200, 1'b0, 1'b1,
           '{1'b0, 32'd3, 42'd50000}},
         '{ROW_CSR,  bedr_pkg::CSR_BLOCK_LEN, 42'd4, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
         '{ROW_CSR,  bedr_pkg::CSR_ALPHA, 42'd384, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
         '{ROW_WORD, bedr_pkg::CSR_ALPHA, 42'd0, 16'sd300, 16'sd400, 1'b0, 1'b0, '0},
         '{ROW_WORD, bedr_pkg::CSR_ALPHA, 42'd0, -16'sd5000, 16'sd7, 1'b0, 1'b0, '0},
         '{ROW_WORD, bedr_pkg::CSR_ALPHA, 42'd0, 16'sd20000, -16'sd20000, 1'b0, 1'b0, '0},
         '{ROW_CSR,  bedr_pkg::CSR_BLOCK_LEN, 42'd2, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
         '{ROW_WORD, bedr_pkg::CSR_ALPHA, 42'd0, 16'sd12, 16'sd34, 1'b0, 1'b0, '0},
         '{ROW_WORD, bedr_pkg::CSR_ALPHA, 42'd0, 16'sd1000, 16'sd1000, 1'b0, 1'b0, '0},
         '{ROW_WORD, bedr_pkg::CSR_ALPHA, 42'd0, -16'sd1000, 16'sd5, 1'b1, 1'b0, '0},
         '{ROW_WORD, bedr_pkg::CSR_ALPHA, 42'd0, 16'sd7, -16'sd7, 1'b0, 1'b0, '0},
         '{ROW_CSR,  bedr_pkg::CSR_ALPHA, 42'd256, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
         '{ROW_CSR,  bedr_pkg::CSR_BLOCK_LEN, 42'd1, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
         '{ROW_WORD, bedr_pkg::CSR_ALPHA, 42'd0, 16'sh7fff, 16'sh8000, 1'b0, 1'b0, '0}
      };

      repeat (7) @(posedge clock);
      reset   <= 1'b0;
      m_alpha = bedr_pkg::ALPHA_RESET;
      m_len   = bedr_pkg::BLOCK_LEN_RESET;
      m_prev  = 64'(bedr_pkg::ENERGY_RESET);
      m_sum   = '0;
      m_count = '0;
      m_off   = '0;

      foreach (dir_rows[r]) begin
         if (dir_rows[r].kind == ROW_CSR) write_reg(dir_rows[r].reg_idx, dir_rows[r].data);
         else send_word(dir_rows[r].si, dir_rows[r].sq, dir_rows[r].ns,
                        dir_rows[r].typed, dir_rows[r].want);
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         big = (ph == 5);
         if (ph == 0) alpha_val = '1;
         else if (ph == 1) alpha_val = '0;
         else if ($urandom_range(0, 3) == 0) alpha_val = bedr_pkg::ALPHA_W'($urandom);
         else alpha_val = bedr_pkg::ALPHA_W'($urandom_range(128, 768));
         if (big) len_val = '1;
         else if (ph == 1) len_val = '0;
         else if (ph == 2) len_val = 11'd1;
         else if ($urandom_range(0, 3) == 0)
            len_val = bedr_pkg::BLK_LEN_W'($urandom_range(10, 40));
         else len_val = bedr_pkg::BLK_LEN_W'($urandom_range(1, 9));
         write_reg(bedr_pkg::CSR_ALPHA, {26'($urandom), alpha_val});
         write_reg(bedr_pkg::CSR_BLOCK_LEN, {31'($urandom), len_val});
         if (ph % 3 == 0) begin
            if (ph == 0) init_val = bedr_pkg::ENERGY_MAX;
            else if (ph == 3) init_val = '0;
            else init_val = {10'($urandom), 32'($urandom)};
            write_reg(bedr_pkg::CSR_INITIAL_ENERGY, init_val);
         end
         idle_mode = idle_type'(ph % 4);
         n_items = big ? BIG_PHASE_WORDS : PHASE_WORDS;
         for (int k = 0; k < n_items; k++) begin
            if (big) begin
               si = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
               sq = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
               ns = 1'b0;
            end else begin
               si = 16'($urandom);
               si = si >>> $urandom_range(0, 15);
               sq = 16'($urandom);
               sq = sq >>> $urandom_range(0, 15);
               case ($urandom_range(0, 9))
                  0: si = 16'sh8000;
                  1: sq = 16'sh7fff;
                  2: begin
                     si = 16'sh8000;
                     sq = 16'sh8000;
                  end
                  default: ;
               endcase
               ns = ($urandom_range(0, 19) == 0);
            end
            send_word(si, sq, ns, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      idle_mode = IDLE_NONE;
      while (pending_blocks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d sample words over %0d settings, %0d block results (%0d detections)",
               n_words, NUM_PHASES + 1, n_results, n_hits);
      $display("idle patterns: none, sender gaps, receiver stalls, light on both; %0d errors",
               errors);
      if (errors == 0) $display("tb_block_energy_rise_detector_unit: PASS");
      else $display("tb_block_energy_rise_detector_unit: FAIL");
      $finish;
   end

endmodule
